// ----- hw/rtl/spcm_pkg.sv -----
package spcm_pkg;

  localparam int X_FRAC_BITS = 8;

  localparam int PCT1 = 100 * 1 / 6;
  localparam int PCT2 = 100 * 2 / 6;
  localparam int PCT4 = 100 * 4 / 6;
  localparam int PCT5 = 100 * 5 / 6;
  localparam int HALF_SPAN = 50 - 0;
  localparam int FULL_SPAN = 100 - 0;

  // Reciprocals for exact division by 100 and 50 of values below 2^30.
  localparam logic [25:0] RECIP100 = 26'd42949673;
  localparam logic [26:0] RECIP50 = 27'd85899346;

  localparam int QW = 17;

  typedef enum logic [2:0] {
    CFG_RANGE_LOW      = 3'd0,
    CFG_RANGE_HIGH     = 3'd1,
    CFG_OUT_MIN        = 3'd2,
    CFG_OUT_MID        = 3'd3,
    CFG_OUT_MAX        = 3'd4,
    CFG_POINT_PERCENTS = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] range_low;
    logic [15:0] range_high;
    logic [15:0] out_min;
    logic [15:0] out_mid;
    logic [15:0] out_max;
    logic [55:0] point_percents;
  } cfg_t;

  typedef struct packed {
    logic [15:0] x;
    logic [2:0]  ia;
    logic [2:0]  ib;
    logic [15:0] w;
    logic [15:0] dx;
  } seg_t;

  typedef struct packed {
    logic [15:0]   x;
    logic [16:0]   rem;
    logic [16:0]   dvd;
    logic [QW-1:0] quo;
    logic [15:0]   w;
    logic          neg;
  } dstep_t;

endpackage

// ----- hw/rtl/spcm_front.sv -----
module spcm_front import spcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [15:0] up_x,
  output logic        dn_valid,
  input  logic        dn_ready,
  output seg_t        dn_seg
);

  localparam int NS = 3;
  localparam logic [6:0] FRAC_PCT [4] = '{7'(PCT1), 7'(PCT2), 7'(PCT4), 7'(PCT5)};
  localparam int FRAC_POS [4] = '{1, 2, 4, 5};

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  logic [15:0] x1_r;
  logic [16:0] d1_r;
  logic [22:0] prod1_r [4];
  logic [16:0] d_nxt;
  logic [22:0] prod_nxt [4];

  logic [15:0] x2_r;
  logic [15:0] xb2_r [7];
  logic [15:0] xb_nxt [7];
  logic [48:0] mq [4];

  seg_t seg3_r;
  seg_t seg_nxt;
  logic found;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || dn_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];
  assign dn_seg = seg3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  always_comb begin
    d_nxt = 17'($signed({cfg.range_high[15], cfg.range_high}) -
                $signed({cfg.range_low[15], cfg.range_low}));
    for (int k = 0; k < 4; k++) begin
      prod_nxt[k] = 23'(d_nxt) * 23'(FRAC_PCT[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 7; k++) begin
      xb_nxt[k] = cfg.range_low;
    end
    for (int k = 0; k < 4; k++) begin
      mq[k] = 49'(prod1_r[k]) * 49'(RECIP100);
      xb_nxt[FRAC_POS[k]] = cfg.range_low + 16'(mq[k][48:32]);
    end
    xb_nxt[3] = cfg.range_low + d1_r[16:1];
    xb_nxt[6] = cfg.range_high;
  end

  always_comb begin
    seg_nxt.x = x2_r;
    seg_nxt.ia = 3'd6;
    seg_nxt.ib = 3'd6;
    seg_nxt.w = 16'd1;
    seg_nxt.dx = '0;
    found = 1'b0;
    if ($signed(x2_r) < $signed(xb2_r[0])) begin
      seg_nxt.ia = 3'd0;
      seg_nxt.ib = 3'd0;
    end else if ($signed(x2_r) <= $signed(xb2_r[6])) begin
      for (int k = 0; k < 6; k++) begin
        if (!found && $signed(x2_r) >= $signed(xb2_r[k]) &&
            ($signed(x2_r) < $signed(xb2_r[k+1]) ||
             (k == 5 && $signed(x2_r) <= $signed(xb2_r[k+1])))) begin
          found = 1'b1;
          if ($signed(xb2_r[k+1]) > $signed(xb2_r[k])) begin
            seg_nxt.ia = 3'(k);
            seg_nxt.ib = 3'(k + 1);
            seg_nxt.w = xb2_r[k+1] - xb2_r[k];
            seg_nxt.dx = x2_r - xb2_r[k];
          end else begin
            seg_nxt.ia = 3'(k + 1);
            seg_nxt.ib = 3'(k + 1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x1_r <= up_x;
      d1_r <= d_nxt;
      prod1_r <= prod_nxt;
    end
    if (rdy[1]) begin
      x2_r <= x1_r;
      xb2_r <= xb_nxt;
    end
    if (rdy[2]) begin
      seg3_r <= seg_nxt;
    end
  end

endmodule

// ----- hw/rtl/spcm_interp.sv -----
module spcm_interp import spcm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   up_valid,
  output logic   up_ready,
  input  seg_t   up_seg,
  output logic   dn_valid,
  input  logic   dn_ready,
  output dstep_t dn_st
);

  localparam int NS = 4;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  logic [15:0] x4_r, w4_r, dx4_r;
  logic [15:0] base4_r [2];
  logic [21:0] prod4_r [2];
  logic [15:0] base_nxt [2];
  logic [21:0] prod_nxt [2];
  logic [15:0] dl, dh, mult;
  logic [2:0]  idx;
  logic [6:0]  pct;
  logic [5:0]  frac;

  logic [15:0] x5_r, w5_r, dx5_r;
  logic [15:0] y5_r [2];
  logic [15:0] y_nxt [2];
  logic [48:0] mq [2];

  logic [15:0] x6_r, w6_r;
  logic signed [32:0] m1_r, m1_nxt;
  logic signed [33:0] m2_r, m2_nxt;
  logic signed [16:0] dy;

  dstep_t st7_r, st_nxt;
  logic signed [34:0] num;
  logic [34:0] mag;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || dn_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];
  assign dn_st = st7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  always_comb begin
    dl = cfg.out_mid - cfg.out_min;
    dh = cfg.out_max - cfg.out_mid;
    idx = '0;
    pct = '0;
    frac = '0;
    mult = '0;
    for (int e = 0; e < 2; e++) begin
      idx = (e == 0) ? up_seg.ia : up_seg.ib;
      pct = (cfg.point_percents[{idx, 3'b000} +: 8] > 8'(FULL_SPAN)) ?
            7'(FULL_SPAN) : cfg.point_percents[{idx, 3'b000} +: 7];
      if (pct <= 7'(HALF_SPAN)) begin
        base_nxt[e] = cfg.out_min;
        mult = dl;
        frac = 6'(pct);
      end else begin
        base_nxt[e] = cfg.out_mid;
        mult = dh;
        frac = 6'(pct - 7'(HALF_SPAN));
      end
      prod_nxt[e] = 22'(mult) * 22'(frac);
    end
  end

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      mq[e] = 49'(prod4_r[e]) * 49'(RECIP50);
      y_nxt[e] = base4_r[e] + 16'(mq[e][48:32]);
    end
  end

  always_comb begin
    dy = $signed({y5_r[1][15], y5_r[1]}) - $signed({y5_r[0][15], y5_r[0]});
    m1_nxt = $signed(y5_r[0]) * $signed({1'b0, w5_r});
    m2_nxt = dy * $signed({1'b0, dx5_r});
  end

  always_comb begin
    num = $signed({{2{m1_r[32]}}, m1_r}) + $signed({m2_r[33], m2_r});
    mag = num[34] ? 35'(-num) : 35'(num);
    st_nxt.x = x6_r;
    st_nxt.rem = mag[33:17];
    st_nxt.dvd = mag[16:0];
    st_nxt.quo = '0;
    st_nxt.w = w6_r;
    st_nxt.neg = num[34];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x4_r <= up_seg.x;
      w4_r <= up_seg.w;
      dx4_r <= up_seg.dx;
      base4_r <= base_nxt;
      prod4_r <= prod_nxt;
    end
    if (rdy[1]) begin
      x5_r <= x4_r;
      w5_r <= w4_r;
      dx5_r <= dx4_r;
      y5_r <= y_nxt;
    end
    if (rdy[2]) begin
      x6_r <= x5_r;
      w6_r <= w5_r;
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
    end
    if (rdy[3]) begin
      st7_r <= st_nxt;
    end
  end

endmodule

// ----- hw/rtl/spcm_div.sv -----
module spcm_div import spcm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  dstep_t up_st,
  output logic   dn_valid,
  input  logic   dn_ready,
  output dstep_t dn_st
);

  logic [QW-1:0] v_r;
  logic [QW-1:0] rdy;
  dstep_t        st_r [QW];
  dstep_t        st_nxt [QW];

  function automatic dstep_t div_step(input dstep_t s);
    dstep_t     o;
    logic [16:0] t;
    o = s;
    t = {s.rem[15:0], s.dvd[16]};
    o.dvd = {s.dvd[15:0], 1'b0};
    if (t >= {1'b0, s.w}) begin
      o.rem = t - {1'b0, s.w};
      o.quo = {s.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = t;
      o.quo = {s.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    rdy[QW-1] = !v_r[QW-1] || dn_ready;
    for (int s = QW - 2; s >= 0; s--) begin
      rdy[s] = !v_r[s] || rdy[s+1];
    end
  end

  always_comb begin
    st_nxt[0] = div_step(up_st);
    for (int s = 1; s < QW; s++) begin
      st_nxt[s] = div_step(st_r[s-1]);
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[QW-1];
  assign dn_st = st_r[QW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int s = 1; s < QW; s++) begin
        if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QW; s++) begin
      if (rdy[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

endmodule

// ----- hw/rtl/seven_point_curve_mapper.sv -----
// Maps each signed Q8.8 input through a seven-point piecewise linear curve and returns one
// signed 16-bit result per input, in order. The pipeline is 25 register stages deep: three
// stages place the breakpoints and pick the segment, four build the y points and the
// interpolation numerator, seventeen run a restoring divider one quotient bit per stage, and
// one output register holds the result. While the output is not stalled, a new input
// transfer is taken every cycle and the throughput is one item per cycle; an empty stage
// always accepts, so bubbles close up while the output is stalled. Configuration is written
// through cfg_we, cfg_index and cfg_wdata and must only change while no item is in flight.
module seven_point_curve_mapper import spcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_x_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_curve_out,
  output logic        out_passed_through,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [55:0] cfg_wdata
);

  cfg_t   cfg_r;
  logic   front_rdy, front_vld;
  seg_t   front_seg;
  logic   interp_rdy, interp_vld;
  dstep_t interp_st;
  logic   div_rdy, div_vld;
  dstep_t div_st;
  logic   out_rdy;
  logic   invalid;
  logic [16:0] pass_sum;
  logic [16:0] quo_signed;
  logic [15:0] curve_nxt;
  logic   out_valid_r, pass_r;
  logic [15:0] curve_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_low <= 16'd0;
      cfg_r.range_high <= 16'd25600;
      cfg_r.out_min <= 16'hFF9C;
      cfg_r.out_mid <= 16'd0;
      cfg_r.out_max <= 16'd100;
      cfg_r.point_percents <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_LOW:      cfg_r.range_low <= cfg_wdata[15:0];
        CFG_RANGE_HIGH:     cfg_r.range_high <= cfg_wdata[15:0];
        CFG_OUT_MIN:        cfg_r.out_min <= cfg_wdata[15:0];
        CFG_OUT_MID:        cfg_r.out_mid <= cfg_wdata[15:0];
        CFG_OUT_MAX:        cfg_r.out_max <= cfg_wdata[15:0];
        CFG_POINT_PERCENTS: cfg_r.point_percents <= cfg_wdata;
        default: ;
      endcase
    end
  end

  spcm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (front_rdy),
    .up_x     (in_x_value),
    .dn_valid (front_vld),
    .dn_ready (interp_rdy),
    .dn_seg   (front_seg)
  );

  spcm_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (front_vld),
    .up_ready (interp_rdy),
    .up_seg   (front_seg),
    .dn_valid (interp_vld),
    .dn_ready (div_rdy),
    .dn_st    (interp_st)
  );

  spcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (interp_vld),
    .up_ready (div_rdy),
    .up_st    (interp_st),
    .dn_valid (div_vld),
    .dn_ready (out_rdy),
    .dn_st    (div_st)
  );

  assign in_stall = !front_rdy;
  assign out_rdy = !out_valid_r || !out_stall;

  always_comb begin
    invalid = ($signed(cfg_r.out_min) > $signed(cfg_r.out_mid)) ||
              ($signed(cfg_r.out_mid) > $signed(cfg_r.out_max)) ||
              ($signed(cfg_r.range_low) > $signed(cfg_r.range_high));
    pass_sum = $signed({div_st.x[15], div_st.x}) +
               $signed(div_st.x[15] ? 17'((1 << X_FRAC_BITS) - 1) : 17'd0);
    pass_sum = 17'($signed(pass_sum) >>> X_FRAC_BITS);
    quo_signed = div_st.neg ? 17'(-div_st.quo) : div_st.quo;
    curve_nxt = invalid ? pass_sum[15:0] : quo_signed[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      curve_r <= curve_nxt;
      pass_r <= invalid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_curve_out = curve_r;
  assign out_passed_through = pass_r;

endmodule
